/* src/assert_macros.svh */
// assertion macros shared by the envelope generator modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/adsr_pkg.sv */
// shared types and constants of the adsr envelope generator
// no dependencies
package adsr_pkg;

  localparam int LEVEL_BITS_DEFAULT = 12;
  localparam int KNOB_BITS          = 10;
  localparam int MORPH_BITS         = 10;
  localparam int SPEED_BITS         = 11;
  localparam int PHASE_BITS         = 3;
  localparam int CFG_INDEX_BITS     = 4;
  localparam int CFG_DATA_BITS      = 11;
  localparam int SMOOTH_SHIFT       = 3;
  localparam int STEP_SHIFT         = 8;
  localparam int MORPH_SHIFT        = 9;

  localparam logic [MORPH_BITS-1:0] MORPH_RESET = 10'd512;
  localparam logic [SPEED_BITS-1:0] SPEED_RESET = 11'd256;
  localparam logic [SPEED_BITS-1:0] SPEED_MIN   = 11'd5;
  localparam logic [SPEED_BITS-1:0] SPEED_MAX   = 11'd1100;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_CURVE_MORPH = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TIME_SPEED  = 4'd1;

  typedef enum logic [PHASE_BITS-1:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

/* src/adsr_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
// depends on adsr_pkg and assert_macros.svh
`include "assert_macros.svh"

module adsr_div #(
  parameter int NUM_BITS = 15,
  parameter int DEN_BITS = 11
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output adsr_pkg::div_status_t status,
  output logic [NUM_BITS-1:0] quot
);

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] quo;
  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS-1:0] dsr;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic                done;
  logic [DEN_BITS:0]   trial;
  logic                fits;

  assign trial = {rem, quo[NUM_BITS-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= num;
        rem  <= '0;
        dsr  <= den;
        cnt  <= CNT_BITS'(NUM_BITS);
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= DEN_BITS'(trial - {1'b0, dsr});
        end else begin
          rem <= trial[DEN_BITS-1:0];
        end
        quo <= {quo[NUM_BITS-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quot        = quo;

  `ASSERT_CLK(a_start_busy, clk, rst, start |=> busy, "divider did not start")
  `ASSERT_CLK(a_done_idle, clk, rst, done |-> !busy, "divider done while busy")

endmodule

/* src/adsr_mul.sv */
// shared multiplier with registered product
// depends on nothing but its width parameter
module adsr_mul #(
  parameter int WIDTH = 12
) (
  input  logic               clk,
  input  logic               en,
  input  logic [WIDTH-1:0]   a,
  input  logic [WIDTH-1:0]   b,
  output logic [2*WIDTH-1:0] prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

/* src/adsr_envelope_with_curve_morph_top.sv */
// adsr envelope generator with curve morph: sequencer, knob smoothing, phase update
// depends on adsr_pkg, adsr_div, adsr_mul and assert_macros.svh
// Each input word is one control tick and yields one output word. A new tick is
// accepted only once the word of the previous tick has been written to the output
// register. The segment step comes from a radix-2 divider that resolves one
// quotient bit per cycle, and the curve shaping runs four products through one
// shared multiplier. s_tready is high only while no tick is in flight; a finished
// word waits in the output register and the next tick is accepted meanwhile, but
// that tick then holds in its last cycle until the waiting word is taken.
// Configuration writes are taken at any time outside reset and are meant for idle
// periods; an out-of-range speed stores the nominal 256.
`include "assert_macros.svh"

module adsr_envelope_with_curve_morph_top #(
  parameter int LEVEL_BITS = adsr_pkg::LEVEL_BITS_DEFAULT
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        s_tvalid,
  output logic                                        s_tready,
  // sample_first [9:0], sample_second [19:10], zero pad
  input  logic [23:0]                                 s_tdata,
  // gate
  input  logic                                        s_tuser,
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  // shaped_level, raw_level, phase, zero pad
  output logic [((2*LEVEL_BITS+10)/8)*8-1:0]          m_tdata,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [adsr_pkg::CFG_INDEX_BITS-1:0]         cfg_index,
  input  logic [adsr_pkg::CFG_DATA_BITS-1:0]          cfg_data
);

  localparam int LB      = LEVEL_BITS;
  localparam int KB      = adsr_pkg::KNOB_BITS;
  localparam int SB      = adsr_pkg::SPEED_BITS;
  localparam int NUM_W   = LB + SB - adsr_pkg::STEP_SHIFT;
  localparam int DEN_W   = KB + 1;
  localparam int M_W     = ((2*LEVEL_BITS+10)/8)*8;
  localparam int PAD_W   = M_W - 2*LB - adsr_pkg::PHASE_BITS;
  localparam int SUM_W   = 2*LB + 1;
  localparam logic [LB-1:0] LEVEL_MAX = {LB{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_SMOOTH,
    S_DIV_START,
    S_DIV,
    S_UPDATE,
    S_MUL_VV,
    S_MUL_II,
    S_MUL_A,
    S_MUL_B,
    S_FIN
  } state_t;

  state_t                  state;
  adsr_pkg::phase_t        phase;
  adsr_pkg::phase_t        phase_next;
  logic [LB-1:0]           level;
  logic [LB-1:0]           level_next;
  logic [KB-1:0]           attack_knob;
  logic [KB-1:0]           decay_knob;
  logic [KB-1:0]           sustain_knob;
  logic [KB-1:0]           release_knob;
  logic [adsr_pkg::MORPH_BITS-1:0] curve_morph;
  logic [SB-1:0]           time_speed;

  logic                    gate;
  logic [KB-1:0]           sample_first;
  logic [KB-1:0]           sample_second;
  logic [LB-1:0]           expo;
  logic [LB-1:0]           logv;
  logic [2*LB-1:0]         prod_a;

  logic [LB-1:0]           out_shaped;
  logic [LB-1:0]           out_raw;
  adsr_pkg::phase_t        out_phase;
  logic                    fin_fire;

  logic [KB-1:0]           knob_sel;
  logic [LB+SB-1:0]        speed_scaled;
  logic                    div_start;
  adsr_pkg::div_status_t   div_stat;
  logic [NUM_W-1:0]        quot;
  logic [NUM_W-1:0]        step;
  logic [LB+3:0]           step_ext;
  logic [LB+3:0]           level_ext;
  logic [LB+3:0]           target_ext;
  logic [LB-1:0]           target;

  logic                    mul_en;
  logic [LB-1:0]           mul_a;
  logic [LB-1:0]           mul_b;
  logic [2*LB-1:0]         prod;
  logic [LB-1:0]           inv;
  logic [8:0]              weight;
  logic [SUM_W-1:0]        mix_sum;

  function automatic logic [KB-1:0] smooth(input logic [KB-1:0] knob,
                                           input logic [KB-1:0] sample);
    logic [KB+3:0] acc;
    acc = ({1'b0, knob, 3'b000} - {4'b0000, knob}) + {4'b0000, sample};
    return acc[KB+2:adsr_pkg::SMOOTH_SHIFT];
  endfunction

  assign cfg_ready = !rst;
  assign s_tready  = (state == S_IDLE) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_morph <= adsr_pkg::MORPH_RESET;
      time_speed  <= adsr_pkg::SPEED_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == adsr_pkg::CFG_CURVE_MORPH) begin
        curve_morph <= cfg_data[adsr_pkg::MORPH_BITS-1:0];
      end else if (cfg_index == adsr_pkg::CFG_TIME_SPEED) begin
        if (cfg_data < adsr_pkg::SPEED_MIN || cfg_data > adsr_pkg::SPEED_MAX) begin
          time_speed <= adsr_pkg::SPEED_RESET;
        end else begin
          time_speed <= cfg_data;
        end
      end
    end
  end

  // step divider: (LEVEL_MAX * speed / 256) / (knob + 1)
  always_comb begin
    unique case (phase)
      adsr_pkg::PH_DECAY:   knob_sel = decay_knob;
      adsr_pkg::PH_RELEASE: knob_sel = release_knob;
      default:              knob_sel = attack_knob;
    endcase
  end

  assign speed_scaled = ((LB+SB)'(time_speed) << LB) - (LB+SB)'(time_speed);
  assign div_start    = (state == S_DIV_START);

  adsr_div #(
    .NUM_BITS (NUM_W),
    .DEN_BITS (DEN_W)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (speed_scaled[LB+SB-1:adsr_pkg::STEP_SHIFT]),
    .den    ({1'b0, knob_sel} + DEN_W'(1)),
    .status (div_stat),
    .quot   (quot)
  );

  // phase update
  assign step       = (quot == '0) ? NUM_W'(1) : quot;
  assign step_ext   = (LB+4)'(step);
  assign level_ext  = (LB+4)'(level);
  assign target     = LB'(sustain_knob) << (LB - KB);
  assign target_ext = (LB+4)'(target);

  always_comb begin
    phase_next = phase;
    level_next = level;
    unique case (phase)
      adsr_pkg::PH_ATTACK: begin
        if (!gate) begin
          phase_next = adsr_pkg::PH_RELEASE;
        end else if (level_ext + step_ext >= (LB+4)'(LEVEL_MAX)) begin
          level_next = LEVEL_MAX;
          phase_next = adsr_pkg::PH_DECAY;
        end else begin
          level_next = LB'(level_ext + step_ext);
        end
      end
      adsr_pkg::PH_DECAY: begin
        if (!gate) begin
          phase_next = adsr_pkg::PH_RELEASE;
        end else if (level_ext <= target_ext + step_ext) begin
          level_next = target;
          phase_next = adsr_pkg::PH_SUSTAIN;
        end else begin
          level_next = LB'(level_ext - step_ext);
        end
      end
      adsr_pkg::PH_SUSTAIN: begin
        if (!gate) begin
          phase_next = adsr_pkg::PH_RELEASE;
        end else begin
          level_next = target;
        end
      end
      adsr_pkg::PH_RELEASE: begin
        if (gate) begin
          phase_next = adsr_pkg::PH_ATTACK;
        end else if (level_ext <= step_ext) begin
          level_next = '0;
          phase_next = adsr_pkg::PH_IDLE;
        end else begin
          level_next = LB'(level_ext - step_ext);
        end
      end
      default: begin
        level_next = '0;
        phase_next = gate ? adsr_pkg::PH_ATTACK : adsr_pkg::PH_IDLE;
      end
    endcase
  end

  // curve shaping through the shared multiplier
  assign inv    = LEVEL_MAX - level;
  assign weight = curve_morph[8:0];

  always_comb begin
    mul_en = 1'b1;
    mul_a  = level;
    mul_b  = level;
    unique case (state)
      S_MUL_VV: begin
        mul_a = level;
        mul_b = level;
      end
      S_MUL_II: begin
        mul_a = inv;
        mul_b = inv;
      end
      S_MUL_A: begin
        mul_a = curve_morph[adsr_pkg::MORPH_BITS-1] ? level : expo;
        mul_b = LB'(9'd511 - weight);
      end
      S_MUL_B: begin
        mul_a = curve_morph[adsr_pkg::MORPH_BITS-1] ? logv : level;
        mul_b = LB'(weight);
      end
      default: mul_en = 1'b0;
    endcase
  end

  adsr_mul #(
    .WIDTH (LB)
  ) u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign mix_sum  = SUM_W'(prod_a) + SUM_W'(prod);
  assign fin_fire = (state == S_FIN) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= adsr_pkg::PH_IDLE;
      level        <= '0;
      attack_knob  <= '0;
      decay_knob   <= '0;
      sustain_knob <= '0;
      release_knob <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (fin_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            gate          <= s_tuser;
            sample_first  <= s_tdata[KB-1:0];
            sample_second <= s_tdata[2*KB-1:KB];
            state         <= S_SMOOTH;
          end
        end
        S_SMOOTH: begin
          if (gate) begin
            sustain_knob <= smooth(sustain_knob, sample_first);
            release_knob <= smooth(release_knob, sample_second);
          end else begin
            attack_knob <= smooth(attack_knob, sample_first);
            decay_knob  <= smooth(decay_knob, sample_second);
          end
          state <= S_DIV_START;
        end
        S_DIV_START: state <= S_DIV;
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          phase <= phase_next;
          level <= level_next;
          state <= S_MUL_VV;
        end
        S_MUL_VV: state <= S_MUL_II;
        S_MUL_II: begin
          expo  <= prod[2*LB-1:LB];
          state <= S_MUL_A;
        end
        S_MUL_A: begin
          logv  <= LEVEL_MAX - prod[2*LB-1:LB];
          state <= S_MUL_B;
        end
        S_MUL_B: begin
          prod_a <= prod;
          state  <= S_FIN;
        end
        S_FIN: begin
          if (fin_fire) begin
            out_shaped <= mix_sum[LB+adsr_pkg::MORPH_SHIFT-1:adsr_pkg::MORPH_SHIFT];
            out_raw    <= level;
            out_phase  <= phase;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {{PAD_W{1'b0}}, out_phase, out_raw, out_shaped};

  `ASSERT_CLK(a_idle_level_zero, clk, rst, m_tvalid && out_phase == adsr_pkg::PH_IDLE |-> out_raw == '0, "idle word with nonzero level")
  `ASSERT_CLK(a_div_done_wait, clk, rst, div_stat.done |-> state == S_DIV, "divider finished outside wait")
  `ASSERT_CLK(a_accept_smooth, clk, rst, s_tvalid && s_tready |=> state == S_SMOOTH, "accepted word not smoothed next")

endmodule
